@@ design/hsps_pkg.sv @@
`default_nettype none
package hsps_pkg;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    localparam logic [7:0]  EPB_BYTE       = 8'h03;
    localparam logic [15:0] REF_SAT        = 16'hFFFF;
    localparam logic [1:0]  CHROMA_IDC_444 = 2'd3;
    localparam logic [1:0]  POC_TYPE_LSB   = 2'd0;
    localparam logic [1:0]  POC_TYPE_CYCLE = 2'd1;
    localparam logic [3:0]  FIELD_BYTE_LEN = 4'd8;
    localparam logic [3:0]  FIELD_FLAG_LEN = 4'd1;
    localparam logic [3:0]  FIELD_UE_LEN   = 4'd0;

    localparam logic [7:0] PROF_HIGH      = 8'd100;
    localparam logic [7:0] PROF_HIGH10    = 8'd110;
    localparam logic [7:0] PROF_HIGH422   = 8'd122;
    localparam logic [7:0] PROF_HIGH444   = 8'd244;
    localparam logic [7:0] PROF_CAVLC444  = 8'd44;
    localparam logic [7:0] PROF_SCAL_HIGH = 8'd83;
    localparam logic [7:0] PROF_MVC_HIGH  = 8'd86;

    typedef enum logic [1:0] {
        PS_OK      = 2'd0,
        PS_TRUNC   = 2'd1,
        PS_UNSUP   = 2'd2,
        PS_UNUSED  = 2'd3
    } parse_status_t;

    typedef enum logic [4:0] {
        F_PROFILE   = 5'd0,
        F_CONSTR    = 5'd1,
        F_LEVEL     = 5'd2,
        F_SPSID     = 5'd3,
        F_CHROMA    = 5'd4,
        F_SEPCOL    = 5'd5,
        F_BDLUMA    = 5'd6,
        F_BDCHROMA  = 5'd7,
        F_QPBYPASS  = 5'd8,
        F_SCALING   = 5'd9,
        F_FRAMENUM  = 5'd10,
        F_POCTYPE   = 5'd11,
        F_POCLSB    = 5'd12,
        F_MAXREF    = 5'd13,
        F_GAPS      = 5'd14,
        F_WIDTH     = 5'd15,
        F_HEIGHT    = 5'd16,
        F_FRAMEMBS  = 5'd17,
        F_MBAFF     = 5'd18,
        F_DIRECT    = 5'd19,
        F_CROPFLAG  = 5'd20,
        F_CROP0     = 5'd21,
        F_CROP1     = 5'd22,
        F_CROP2     = 5'd23,
        F_CROP3     = 5'd24,
        F_DONE      = 5'd25,
        F_UNSUP     = 5'd26
    } field_t;

    // branch flag bits
    localparam int FL_HIGH  = 0;
    localparam int FL_C444  = 1;
    localparam int FL_INTER = 2;
    localparam int FL_CROP  = 3;

    typedef struct packed {
        logic [4:0]    pad;
        parse_status_t parse_status;
        logic [15:0]   ref_frame_count;
        logic          interlaced;
        logic [7:0]    level_code;
        logic [7:0]    profile_code;
    } m_data_t;

    typedef struct packed {
        logic load_byte;
        logic shift_bit;
        logic load_out;
        logic clear;
    } dp_cmd_t;

    typedef struct packed {
        logic drop_byte;
    } dp_sts_t;

    function automatic logic is_fixed(input field_t s);
        case (s)
            F_PROFILE, F_CONSTR, F_LEVEL, F_SEPCOL, F_QPBYPASS, F_SCALING,
            F_GAPS, F_FRAMEMBS, F_MBAFF, F_DIRECT, F_CROPFLAG: is_fixed = 1'b1;
            default: is_fixed = 1'b0;
        endcase
    endfunction

    function automatic logic [3:0] field_len(input field_t s);
        if (s == F_PROFILE || s == F_CONSTR || s == F_LEVEL) begin
            field_len = FIELD_BYTE_LEN;
        end else if (is_fixed(s)) begin
            field_len = FIELD_FLAG_LEN;
        end else begin
            field_len = FIELD_UE_LEN;
        end
    endfunction

endpackage
`default_nettype wire

@@ design/hsps_ctrl.sv @@
`default_nettype none
module hsps_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    input  wire logic             s_tlast,
    output logic                  s_tready,
    input  wire logic             m_tready,
    output logic                  m_tvalid,
    input  wire hsps_pkg::dp_sts_t sts,
    output hsps_pkg::dp_cmd_t     cmd
);
    import hsps_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_BITS = 3'b010,
        C_OUT  = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic        last_reg, last_next;
    logic        m_valid_reg, m_valid_next;
    logic        accept;
    logic        out_free;

    always_comb begin
        s_tready = (state_reg == C_IDLE) ||
                   (state_reg == C_BITS && bit_cnt_reg == 3'd7 && !last_reg);
        accept   = s_tvalid && s_tready;
        out_free = !m_valid_reg || m_tready;

        cmd.load_byte = accept;
        cmd.shift_bit = (state_reg == C_BITS);
        cmd.load_out  = (state_reg == C_OUT) && out_free;
        cmd.clear     = (state_reg == C_OUT) && out_free;

        state_next   = state_reg;
        bit_cnt_next = (state_reg == C_BITS) ? bit_cnt_reg + 3'd1 : 3'd0;
        last_next    = accept ? s_tlast : last_reg;
        m_valid_next = cmd.load_out ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

        case (state_reg)
            C_IDLE: begin
                if (accept) begin
                    if (sts.drop_byte) begin
                        state_next = s_tlast ? C_OUT : C_IDLE;
                    end else begin
                        state_next = C_BITS;
                    end
                end
            end
            C_BITS: begin
                if (bit_cnt_reg == 3'd7) begin
                    if (accept) begin
                        if (sts.drop_byte) begin
                            state_next = s_tlast ? C_OUT : C_IDLE;
                        end else begin
                            state_next = C_BITS;
                        end
                    end else begin
                        state_next = last_reg ? C_OUT : C_IDLE;
                    end
                end
            end
            C_OUT: begin
                if (out_free) begin
                    state_next = C_IDLE;
                end
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= C_IDLE;
            bit_cnt_reg <= 3'd0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule
`default_nettype wire

@@ design/hsps_dp.sv @@
`default_nettype none
module hsps_dp #(
    parameter int MAX_GOLOMB_ZEROS = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic [hsps_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  wire hsps_pkg::dp_cmd_t                  cmd,
    output hsps_pkg::dp_sts_t                       sts,
    output logic [hsps_pkg::OUT_TDATA_W-1:0]        m_tdata
);
    import hsps_pkg::*;

    localparam int GZ_W = $clog2(MAX_GOLOMB_ZEROS + 1);
    localparam int FV_W = MAX_GOLOMB_ZEROS + 1;

    logic [7:0]      byte_reg, byte_next;
    logic [1:0]      zero_run_reg, zero_run_next;
    field_t          step_reg, step_next;
    logic [GZ_W-1:0] bits_left_reg, bits_left_next;
    logic [GZ_W-1:0] gz_reg, gz_next;
    logic [FV_W-1:0] fv_reg, fv_next;
    logic            suffix_reg, suffix_next;
    logic [7:0]      profile_reg, profile_next;
    logic [7:0]      level_reg, level_next;
    logic [3:0]      flags_reg, flags_next;
    logic [15:0]     ref_reg, ref_next;
    m_data_t         out_reg, out_next;

    logic            bit_in;
    logic            fin;
    logic [FV_W-1:0] fin_val;
    logic [FV_W-1:0] fv_sh;
    logic [GZ_W-1:0] bl_dec;
    field_t          nx;
    parse_status_t   status_now;

    assign sts.drop_byte = zero_run_reg[1] && (s_tdata == EPB_BYTE);

    always_comb begin
        byte_next     = byte_reg;
        zero_run_next = zero_run_reg;
        if (cmd.load_byte) begin
            byte_next = s_tdata;
            if (sts.drop_byte || s_tdata != 8'd0) begin
                zero_run_next = 2'd0;
            end else if (!zero_run_reg[1]) begin
                zero_run_next = zero_run_reg + 2'd1;
            end
        end else if (cmd.shift_bit) begin
            byte_next = {byte_reg[6:0], 1'b0};
        end
        if (cmd.clear) begin
            zero_run_next = 2'd0;
        end
    end

    always_comb begin
        bit_in         = byte_reg[7];
        fv_sh          = {fv_reg[FV_W-2:0], bit_in};
        bl_dec         = bits_left_reg - GZ_W'(bits_left_reg != '0);
        fin            = 1'b0;
        fin_val        = fv_sh;
        nx             = step_reg;

        step_next      = step_reg;
        bits_left_next = bits_left_reg;
        gz_next        = gz_reg;
        fv_next        = fv_reg;
        suffix_next    = suffix_reg;
        profile_next   = profile_reg;
        level_next     = level_reg;
        flags_next     = flags_reg;
        ref_next       = ref_reg;

        if (cmd.shift_bit && step_reg != F_DONE && step_reg != F_UNSUP) begin
            if (is_fixed(step_reg)) begin
                fv_next        = fv_sh;
                bits_left_next = bl_dec;
                fin            = (bl_dec == '0);
                fin_val        = fv_sh;
            end else if (!suffix_reg) begin
                if (!bit_in) begin
                    if (gz_reg >= GZ_W'(MAX_GOLOMB_ZEROS)) begin
                        step_next      = F_UNSUP;
                        fv_next        = '0;
                        gz_next        = '0;
                        bits_left_next = '0;
                    end else begin
                        gz_next = gz_reg + GZ_W'(1);
                    end
                end else begin
                    // leading one kept in the value register, value is word minus one
                    suffix_next    = 1'b1;
                    bits_left_next = gz_reg;
                    fv_next        = FV_W'(1);
                    fin            = (gz_reg == '0);
                    fin_val        = '0;
                end
            end else begin
                fv_next        = fv_sh;
                bits_left_next = bl_dec;
                fin            = (bl_dec == '0);
                fin_val        = fv_sh - FV_W'(1);
            end
        end

        if (fin) begin
            case (step_reg)
                F_PROFILE: begin
                    profile_next = fin_val[7:0];
                    if (fin_val[7:0] inside {PROF_HIGH, PROF_HIGH10, PROF_HIGH422,
                                             PROF_HIGH444, PROF_CAVLC444,
                                             PROF_SCAL_HIGH, PROF_MVC_HIGH}) begin
                        flags_next[FL_HIGH] = 1'b1;
                    end
                    nx = F_CONSTR;
                end
                F_CONSTR:   nx = F_LEVEL;
                F_LEVEL: begin
                    level_next = fin_val[7:0];
                    nx = F_SPSID;
                end
                F_SPSID:    nx = flags_reg[FL_HIGH] ? F_CHROMA : F_FRAMENUM;
                F_CHROMA: begin
                    if (fin_val == FV_W'(CHROMA_IDC_444)) begin
                        flags_next[FL_C444] = 1'b1;
                        nx = F_SEPCOL;
                    end else begin
                        nx = F_BDLUMA;
                    end
                end
                F_SEPCOL:   nx = F_BDLUMA;
                F_BDLUMA:   nx = F_BDCHROMA;
                F_BDCHROMA: nx = F_QPBYPASS;
                F_QPBYPASS: nx = F_SCALING;
                F_SCALING:  nx = fin_val[0] ? F_UNSUP : F_FRAMENUM;
                F_FRAMENUM: nx = F_POCTYPE;
                F_POCTYPE: begin
                    if (fin_val == FV_W'(POC_TYPE_LSB)) begin
                        nx = F_POCLSB;
                    end else if (fin_val == FV_W'(POC_TYPE_CYCLE)) begin
                        nx = F_UNSUP;
                    end else begin
                        nx = F_MAXREF;
                    end
                end
                F_POCLSB:   nx = F_MAXREF;
                F_MAXREF: begin
                    ref_next = (fin_val > FV_W'(REF_SAT)) ? REF_SAT : fin_val[15:0];
                    nx = F_GAPS;
                end
                F_GAPS:     nx = F_WIDTH;
                F_WIDTH:    nx = F_HEIGHT;
                F_HEIGHT:   nx = F_FRAMEMBS;
                F_FRAMEMBS: begin
                    if (!fin_val[0]) begin
                        flags_next[FL_INTER] = 1'b1;
                        nx = F_MBAFF;
                    end else begin
                        nx = F_DIRECT;
                    end
                end
                F_MBAFF:    nx = F_DIRECT;
                F_DIRECT:   nx = F_CROPFLAG;
                F_CROPFLAG: begin
                    if (fin_val[0]) begin
                        flags_next[FL_CROP] = 1'b1;
                        nx = F_CROP0;
                    end else begin
                        nx = F_DONE;
                    end
                end
                F_CROP0:    nx = F_CROP1;
                F_CROP1:    nx = F_CROP2;
                F_CROP2:    nx = F_CROP3;
                F_CROP3:    nx = F_DONE;
                default:    nx = F_UNSUP;
            endcase
            step_next      = nx;
            fv_next        = '0;
            gz_next        = '0;
            suffix_next    = 1'b0;
            bits_left_next = GZ_W'(field_len(nx));
        end

        if (cmd.clear) begin
            step_next      = F_PROFILE;
            bits_left_next = GZ_W'(FIELD_BYTE_LEN);
            gz_next        = '0;
            fv_next        = '0;
            suffix_next    = 1'b0;
            profile_next   = 8'd0;
            level_next     = 8'd0;
            flags_next     = 4'd0;
            ref_next       = 16'd0;
        end
    end

    always_comb begin
        if (step_reg == F_DONE) begin
            status_now = PS_OK;
        end else if (step_reg == F_UNSUP) begin
            status_now = PS_UNSUP;
        end else begin
            status_now = PS_TRUNC;
        end
        out_next = out_reg;
        if (cmd.load_out) begin
            out_next.pad             = '0;
            out_next.parse_status    = status_now;
            out_next.ref_frame_count = ref_reg;
            out_next.interlaced      = flags_reg[FL_INTER];
            out_next.level_code      = level_reg;
            out_next.profile_code    = profile_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_run_reg  <= 2'd0;
            step_reg      <= F_PROFILE;
            bits_left_reg <= GZ_W'(FIELD_BYTE_LEN);
            gz_reg        <= '0;
            fv_reg        <= '0;
            suffix_reg    <= 1'b0;
            profile_reg   <= 8'd0;
            level_reg     <= 8'd0;
            flags_reg     <= 4'd0;
            ref_reg       <= 16'd0;
        end else begin
            zero_run_reg  <= zero_run_next;
            step_reg      <= step_next;
            bits_left_reg <= bits_left_next;
            gz_reg        <= gz_next;
            fv_reg        <= fv_next;
            suffix_reg    <= suffix_next;
            profile_reg   <= profile_next;
            level_reg     <= level_next;
            flags_reg     <= flags_next;
            ref_reg       <= ref_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        out_reg  <= out_next;
    end

    assign m_tdata = out_reg;

endmodule
`default_nettype wire

@@ design/h264_sps_header_parser_core.sv @@
// Throughput: one bit per cycle through the field walker; the next byte of a set is taken
// during the last bit of the current one, and a dropped emulation-prevention byte is not walked.
// Result: loaded in the output-load state once the bits of the last byte are walked, or
// without a walk if that byte is dropped; later while the previous result waits.
// Reset: aresetn is synchronous, active low; it and every result load return the
// parser to the profile field with all fields cleared.
`default_nettype none
module h264_sps_header_parser_core #(
    parameter int MAX_GOLOMB_ZEROS = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [hsps_pkg::IN_TDATA_W-1:0]  s_tdata,  // [7:0] data_byte
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [7:0] profile_code, [15:8] level_code, [16] interlaced,
    // [32:17] ref_frame_count, [34:33] parse_status, [39:35] zero
    output logic [hsps_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import hsps_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    hsps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    hsps_dp #(
        .MAX_GOLOMB_ZEROS (MAX_GOLOMB_ZEROS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata)
    );

endmodule
`default_nettype wire

@@ design/hsps_checker.sv @@
`default_nettype none
module hsps_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic [hsps_pkg::IN_TDATA_W-1:0]  s_tdata,
    input wire logic                             s_tlast,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [hsps_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import hsps_pkg::*;

    m_data_t res;
    assign res = m_tdata;

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transfer dropped while stalled");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res.parse_status != PS_UNUSED && res.pad == '0))
        else $error("illegal status or padding in result");

    a_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken right after last byte of a set");

    a_data_used: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast && s_tdata != EPB_BYTE |=> !s_tready)
        else $error("coded byte not walked bit by bit");

endmodule

bind h264_sps_header_parser_core hsps_checker u_hsps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

@@ test/h264_sps_header_parser_core_tb.sv @@
`default_nettype none
module h264_sps_header_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsps_pkg::*;

    localparam int GOLOMB_LIMIT = 32;
    localparam int ITEM_TARGET  = 1450;
    localparam int CALM_TAIL    = 150;

    class sps_scoreboard;
        field_t      step;
        logic [5:0]  bits_left;
        logic [5:0]  zeros;
        logic [32:0] acc;
        bit          plain;
        bit          suffix;
        logic [1:0]  zrun;
        logic [7:0]  prof;
        logic [7:0]  lvl;
        bit          high;
        bit          inter;
        logic [15:0] refs;
        m_data_t     pending[$];
        int          mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            zrun  = 2'd0;
            prof  = 8'd0;
            lvl   = 8'd0;
            high  = 1'b0;
            inter = 1'b0;
            refs  = 16'd0;
            begin_field(F_PROFILE);
        endfunction

        function void begin_field(field_t f);
            step   = f;
            acc    = '0;
            zeros  = '0;
            suffix = 1'b0;
            case (f)
                F_PROFILE, F_CONSTR, F_LEVEL: bits_left = 6'd8;
                F_SEPCOL, F_QPBYPASS, F_SCALING, F_GAPS, F_FRAMEMBS, F_MBAFF,
                F_DIRECT, F_CROPFLAG: bits_left = 6'd1;
                default: bits_left = 6'd0;
            endcase
            plain = (bits_left != 6'd0);
        endfunction

        function void end_field(logic [33:0] v);
            field_t nx;
            nx = field_t'(step + 5'd1);
            case (step)
                F_PROFILE: begin
                    prof = v[7:0];
                    if (v == PROF_HIGH || v == PROF_HIGH10 || v == PROF_HIGH422 ||
                        v == PROF_HIGH444 || v == PROF_CAVLC444 ||
                        v == PROF_SCAL_HIGH || v == PROF_MVC_HIGH) begin
                        high = 1'b1;
                    end
                end
                F_LEVEL: lvl = v[7:0];
                F_SPSID: nx = high ? F_CHROMA : F_FRAMENUM;
                F_CHROMA: nx = (v == CHROMA_IDC_444) ? F_SEPCOL : F_BDLUMA;
                F_SCALING: nx = (v != 0) ? F_UNSUP : F_FRAMENUM;
                F_POCTYPE: begin
                    if (v == POC_TYPE_LSB) nx = F_POCLSB;
                    else if (v == POC_TYPE_CYCLE) nx = F_UNSUP;
                    else nx = F_MAXREF;
                end
                F_MAXREF: refs = (v > REF_SAT) ? REF_SAT : v[15:0];
                F_FRAMEMBS: begin
                    if (v == 0) inter = 1'b1;
                    nx = (v == 0) ? F_MBAFF : F_DIRECT;
                end
                F_CROPFLAG: nx = (v != 0) ? F_CROP0 : F_DONE;
                F_CROP3: nx = F_DONE;
                default: ;
            endcase
            begin_field(nx);
        endfunction

        function void push_bit(bit b);
            logic [33:0] base;
            if (step >= F_DONE) return;
            if (plain) begin
                acc = {acc[31:0], b};
                if (bits_left > 0) bits_left--;
                if (bits_left == 0) end_field({1'b0, acc});
                return;
            end
            if (!suffix) begin
                if (!b) begin
                    if (zeros >= GOLOMB_LIMIT) begin_field(F_UNSUP);
                    else zeros++;
                    return;
                end
                suffix    = 1'b1;
                bits_left = zeros;
                acc       = '0;
                if (zeros == 0) end_field('0);
                return;
            end
            acc = {acc[31:0], b};
            if (bits_left > 0) bits_left--;
            if (bits_left == 0) begin
                base = (34'd1 << zeros) - 34'd1;
                end_field(base + {1'b0, acc});
            end
        endfunction

        function void note_input(logic [7:0] d, logic is_last);
            m_data_t e;
            if (zrun >= 2 && d == EPB_BYTE) begin
                zrun = 2'd0;
            end else begin
                if (d == 8'd0) zrun = (zrun < 2) ? zrun + 2'd1 : 2'd2;
                else zrun = 2'd0;
                for (int i = 7; i >= 0; i--) push_bit(d[i]);
            end
            if (!is_last) return;
            e = '0;
            e.profile_code    = prof;
            e.level_code      = lvl;
            e.interlaced      = inter;
            e.ref_frame_count = refs;
            if (step == F_DONE) e.parse_status = PS_OK;
            else if (step == F_UNSUP) e.parse_status = PS_UNSUP;
            else e.parse_status = PS_TRUNC;
            pending.push_back(e);
            restart();
        endfunction

        function void check_result(m_data_t got);
            m_data_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result transfer: %h", got);
                end
                return;
            end
            want = pending.pop_front();
            if (got.profile_code !== want.profile_code ||
                got.level_code !== want.level_code ||
                got.interlaced !== want.interlaced ||
                got.ref_frame_count !== want.ref_frame_count ||
                got.parse_status !== want.parse_status) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp prof=%0d lvl=%0d il=%0b ref=%0d st=%0d",
                             want.profile_code, want.level_code, want.interlaced,
                             want.ref_frame_count, want.parse_status);
                    $display("          got prof=%0d lvl=%0d il=%0b ref=%0d st=%0d",
                             got.profile_code, got.level_code, got.interlaced,
                             got.ref_frame_count, got.parse_status);
                end
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;   // [7:0] data_byte
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    // [7:0] profile_code, [15:8] level_code, [16] interlaced,
    // [32:17] ref_frame_count, [34:33] parse_status, [39:35] zero
    logic [OUT_TDATA_W-1:0]  m_tdata;

    sps_scoreboard sb;
    bit            idle_on;
    int            bytes_sent;
    bit            rbsp[$];
    logic [7:0]    sps_bytes[$];
    bit            tiny;

    h264_sps_header_parser_core #(
        .MAX_GOLOMB_ZEROS(GOLOMB_LIMIT)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    // result side: random backpressure bursts
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (idle_on && aresetn && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_data_t'(m_tdata));
    end

    function void put_bits(logic [33:0] v, int n);
        for (int k = n - 1; k >= 0; k--) rbsp.push_back(v[k]);
    endfunction

    function void put_ue(logic [33:0] v);
        logic [33:0] x;
        int          n;
        x = v + 34'd1;
        n = 0;
        for (int k = 0; k < 34; k++) if (x[k]) n = k;
        repeat (n) rbsp.push_back(1'b0);
        put_bits(x, n + 1);
    endfunction

    function logic [33:0] pick_ue();
        int sel;
        if (tiny) return '0;
        sel = $urandom_range(0, 19);
        if (sel < 13) return 34'($urandom_range(0, 7));
        if (sel < 18) return 34'($urandom_range(0, 300));
        return {1'b0, $urandom_range(0, 1) == 1, $urandom};
    endfunction

    function logic [33:0] pick_refs();
        int sel;
        if (tiny) return '0;
        sel = $urandom_range(0, 9);
        if (sel < 6) return 34'($urandom_range(0, 16));
        if (sel < 8) return 34'($urandom_range(65530, 65540));
        return {1'b0, $urandom_range(0, 1) == 1, $urandom};
    endfunction

    function void build_sps(int prof, int scal, int poc);
        logic [7:0]  p;
        logic [7:0]  octet;
        logic [33:0] chroma;
        logic [33:0] poct;
        bit          scaling;
        bit          mbs_only;
        bit          crop;
        bit          ep_on;
        int          zc;
        int          sel;
        rbsp.delete();
        sps_bytes.delete();
        if (prof >= 0) begin
            p = 8'(prof);
        end else begin
            case ($urandom_range(0, 11))
                0: p = 8'd66;
                1: p = 8'd77;
                2: p = 8'd88;
                3: p = PROF_HIGH;
                4: p = PROF_HIGH10;
                5: p = PROF_HIGH422;
                6: p = PROF_HIGH444;
                7: p = PROF_CAVLC444;
                8: p = PROF_SCAL_HIGH;
                9: p = PROF_MVC_HIGH;
                default: p = 8'($urandom_range(0, 255));
            endcase
        end
        put_bits(34'(p), 8);
        put_bits(34'($urandom_range(0, 255)), 8);
        put_bits(34'($urandom_range(0, 255)), 8);
        put_ue(pick_ue());
        if (p inside {PROF_HIGH, PROF_HIGH10, PROF_HIGH422, PROF_HIGH444,
                      PROF_CAVLC444, PROF_SCAL_HIGH, PROF_MVC_HIGH}) begin
            chroma = ($urandom_range(0, 7) == 0) ? pick_ue() : 34'($urandom_range(0, 3));
            if (tiny) chroma = '0;
            put_ue(chroma);
            if (chroma == CHROMA_IDC_444) put_bits(34'($urandom_range(0, 1)), 1);
            put_ue(pick_ue());
            put_ue(pick_ue());
            put_bits(34'($urandom_range(0, 1)), 1);
            scaling = (scal >= 0) ? scal[0] : ($urandom_range(0, 9) == 0);
            put_bits(34'(scaling), 1);
            if (scaling) begin
                repeat ($urandom_range(0, 24)) rbsp.push_back(1'($urandom_range(0, 1)));
            end
        end
        put_ue(pick_ue());
        if (poc >= 0) begin
            poct = 34'(poc);
        end else begin
            sel = $urandom_range(0, 9);
            if (sel < 5) poct = '0;
            else if (sel < 8) poct = 34'd2;
            else if (sel < 9) poct = 34'd1;
            else poct = pick_ue();
        end
        put_ue(poct);
        if (poct == 0) put_ue(pick_ue());
        put_ue(pick_refs());
        put_bits(34'($urandom_range(0, 1)), 1);
        put_ue(pick_ue());
        put_ue(pick_ue());
        mbs_only = 1'($urandom_range(0, 1));
        put_bits(34'(mbs_only), 1);
        if (!mbs_only) put_bits(34'($urandom_range(0, 1)), 1);
        put_bits(34'($urandom_range(0, 1)), 1);
        crop = tiny ? 1'b0 : ($urandom_range(0, 1) == 1);
        put_bits(34'(crop), 1);
        if (crop) repeat (4) put_ue(pick_ue());
        if (!tiny) repeat ($urandom_range(0, 12)) rbsp.push_back(1'($urandom_range(0, 1)));
        rbsp.push_back(1'b1);
        while (rbsp.size() % 8 != 0) rbsp.push_back(1'b0);

        ep_on = ($urandom_range(0, 15) != 0);
        zc = 0;
        for (int k = 0; k < rbsp.size(); k += 8) begin
            for (int j = 0; j < 8; j++) octet[7 - j] = rbsp[k + j];
            if (ep_on && zc >= 2 && octet <= EPB_BYTE) begin
                sps_bytes.push_back(EPB_BYTE);
                zc = 0;
            end
            sps_bytes.push_back(octet);
            zc = (octet == 8'd0) ? zc + 1 : 0;
        end
    endfunction

    task automatic send_octet(logic [7:0] d, logic is_last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = d;
        s_tlast  = is_last;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(d, is_last);
        bytes_sent++;
        if (bytes_sent > ITEM_TARGET - CALM_TAIL) idle_on = 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_set();
        for (int k = 0; k < sps_bytes.size(); k++) begin
            send_octet(sps_bytes[k], k == sps_bytes.size() - 1);
        end
    endtask

    task automatic random_set();
        int sel;
        int idx;
        sel = $urandom_range(0, 19);
        if (sel < 3) begin
            sps_bytes.delete();
            repeat ($urandom_range(1, 10)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: sps_bytes.push_back(8'h00);
                    3:       sps_bytes.push_back(EPB_BYTE);
                    default: sps_bytes.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end else begin
            build_sps(-1, -1, -1);
            if (sel < 6) begin
                idx = $urandom_range(0, sps_bytes.size() - 1);
                sps_bytes[idx] = sps_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
            end else if (sel < 9 && sps_bytes.size() > 1) begin
                idx = $urandom_range(1, sps_bytes.size() - 1);
                while (sps_bytes.size() > idx) void'(sps_bytes.pop_back());
            end
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) sps_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        send_set();
    endtask

    initial begin
        sb         = new();
        idle_on    = 1'b1;
        bytes_sent = 0;
        tiny       = 1'b0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: minimal sets, escaped 0x03, overlong prefix, unsupported syntax
        sps_bytes = '{8'h00};
        send_set();
        sps_bytes = '{8'hFF};
        send_set();
        sps_bytes = '{8'h00, 8'h00, 8'h03, 8'h03, 8'hFF};
        send_set();
        sps_bytes = '{8'h42, 8'h00, 8'h1E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_set();
        tiny = 1'b1;
        build_sps(244, 1, 0);
        send_set();
        build_sps(66, 0, 1);
        send_set();
        tiny = 1'b0;

        while (bytes_sent < ITEM_TARGET) random_set();
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;

        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
design/hsps_pkg.sv
design/hsps_ctrl.sv
design/hsps_dp.sv
design/h264_sps_header_parser_core.sv
design/hsps_checker.sv
test/h264_sps_header_parser_core_tb.sv
